### hdl/sqs_pkg.sv
package sqs_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N = 1 << SINE_TABLE_BITS;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int FRONT_STAGES = 4;
    localparam int DIV_LANES = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_W = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TEX_H = CFG_IDX_W'(1);

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef logic [16:0] sine_rom_t [SINE_N+1];

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [22:0]        quad_w;
        logic [22:0]        quad_h;
        logic signed [23:0] pivot_x;
        logic signed [23:0] pivot_y;
        logic signed [17:0] sin_v;
        logic signed [17:0] cos_v;
        logic [16:0]        u0;
        logic [16:0]        u1;
        logic [16:0]        v0;
        logic [16:0]        v1;
    } sqs_item_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al = {32'd0, a[31:0]};
        ah = {32'd0, a[63:32]};
        bl = {32'd0, b[31:0]};
        bh = {32'd0, b[63:32]};
        ll = al * bl;
        lh = al * bh;
        hl = ah * bl;
        hh = ah * bh;
        mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        lo = {mid[31:0], ll[31:0]};
        hi = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
        return {hi[61:0], lo[63:62]};
    endfunction

    // Taylor terms x^(2n+1)/(2n+1)!, each divided by (2n)(2n+1), signs alternating
    function automatic logic [16:0] sine_entry(input int unsigned k);
        logic [63:0] low, x, x2, term, sum;
        low = HALF_PI_Q62 & 64'(SINE_N - 1);
        x = (HALF_PI_Q62 >> SINE_TABLE_BITS) * 64'(k) + ((low * 64'(k)) >> SINE_TABLE_BITS);
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        term = mul_q62(term, x2) / 64'd6;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd20;
        sum = sum + term;
        term = mul_q62(term, x2) / 64'd42;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd72;
        sum = sum + term;
        term = mul_q62(term, x2) / 64'd110;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd156;
        sum = sum + term;
        term = mul_q62(term, x2) / 64'd210;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd272;
        sum = sum + term;
        term = mul_q62(term, x2) / 64'd342;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd420;
        sum = sum + term;
        term = mul_q62(term, x2) / 64'd506;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd600;
        sum = sum + term;
        term = mul_q62(term, x2) / 64'd702;
        sum = sum - term;
        term = mul_q62(term, x2) / 64'd812;
        sum = sum + term;
        return 17'((sum + (64'd1 << 45)) >> 46);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t t;
        for (int k = 0; k <= SINE_N; k++)
            t[k] = sine_entry(k);
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### hdl/sprite_quad_setup.sv
// Sprite quad setup: one sprite in, four corners out.
// Input: raise start with the sprite fields; the transfer happens at a clock
// edge where start is high and busy is low. Items may follow in consecutive
// cycles until busy rises; busy reflects room for four sprites between the
// front and the corner generator.
// Config: cfg_write with cfg_index (0 texture width, 1 texture height) and
// cfg_data writes a register at the clock edge; other indexes are ignored.
// Write only while no sprite is in flight.
// Output: each corner is shown for one cycle with strobe high, in order
// top-left, top-right, bottom-left, bottom-right; last_corner marks the fourth.
// The receiver cannot hold results off, so none is ever stalled.
// A sprite passes the front stages, the queue, the item register, the offset
// and product stages and the output registers. Throughput is one corner per
// cycle from the corner generator, which loads the next sprite as it issues
// the last corner of the one before; the front divider pipeline (16 steps of
// restoring division, four per stage) takes one sprite per cycle unless busy.
// Reset: texture size returns to 256 by 256 and all in-flight sprites drop.
module sprite_quad_setup (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [23:0]                   pos_x,
    input  logic signed [23:0]                   pos_y,
    input  logic [22:0]                          quad_width,
    input  logic [22:0]                          quad_height,
    input  logic [15:0]                          rot_phase,
    input  logic signed [23:0]                   pivot_x,
    input  logic signed [23:0]                   pivot_y,
    input  logic [12:0]                          region_x,
    input  logic [12:0]                          region_y,
    input  logic [12:0]                          region_w,
    input  logic [12:0]                          region_h,
    input  logic [1:0]                           mirror_bits,
    input  logic                                 cfg_write,
    input  logic [sqs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [12:0]                          cfg_data,
    output logic                                 strobe,
    output logic signed [23:0]                   corner_x,
    output logic signed [23:0]                   corner_y,
    output logic [16:0]                          tex_u,
    output logic [16:0]                          tex_v,
    output logic [1:0]                           corner_index,
    output logic                                 last_corner
);
    import sqs_pkg::*;

    logic [12:0] tex_w_reg, tex_h_reg;
    logic [QPTR_W:0] credit_reg, credit_next;
    logic take, push, pop, empty;
    sqs_item_t push_item, head;

    assign take = start && !busy;
    assign busy = (credit_reg == (QPTR_W+1)'(QDEPTH));

    // hold a credit from transfer until the corner generator loads the sprite
    assign credit_next = credit_reg + (QPTR_W+1)'(take) - (QPTR_W+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_w_reg  <= 13'd256;
            tex_h_reg  <= 13'd256;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (cfg_write && cfg_index == REG_TEX_W)
                tex_w_reg <= cfg_data;
            if (cfg_write && cfg_index == REG_TEX_H)
                tex_h_reg <= cfg_data;
        end
    end

    sqs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .quad_width  (quad_width),
        .quad_height (quad_height),
        .rot_phase   (rot_phase),
        .pivot_x     (pivot_x),
        .pivot_y     (pivot_y),
        .region_x    (region_x),
        .region_y    (region_y),
        .region_w    (region_w),
        .region_h    (region_h),
        .mirror_bits (mirror_bits),
        .tex_w       (tex_w_reg),
        .tex_h       (tex_h_reg),
        .push        (push),
        .push_item   (push_item)
    );

    sqs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    sqs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .strobe       (strobe),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .corner_index (corner_index),
        .last_corner  (last_corner)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("credit count out of range");
    a_pop_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> credit_reg != '0)
        else $error("sprite loaded without a credit");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg == '0 && !$past(take) |-> !push)
        else $error("front produced a sprite that was never taken");
`endif

endmodule

### hdl/sqs_front.sv
module sqs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic signed [23:0]   pos_x,
    input  logic signed [23:0]   pos_y,
    input  logic [22:0]          quad_width,
    input  logic [22:0]          quad_height,
    input  logic [15:0]          rot_phase,
    input  logic signed [23:0]   pivot_x,
    input  logic signed [23:0]   pivot_y,
    input  logic [12:0]          region_x,
    input  logic [12:0]          region_y,
    input  logic [12:0]          region_w,
    input  logic [12:0]          region_h,
    input  logic [1:0]           mirror_bits,
    input  logic [12:0]          tex_w,
    input  logic [12:0]          tex_h,
    output logic                 push,
    output sqs_pkg::sqs_item_t   push_item
);
    import sqs_pkg::*;

    typedef struct packed {
        logic [12:0] rem;
        logic [15:0] quo;
        logic        sat;
        logic        zero;
    } div_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [22:0]        quad_w;
        logic [22:0]        quad_h;
        logic signed [23:0] pivot_x;
        logic signed [23:0] pivot_y;
        logic signed [17:0] sin_v;
        logic signed [17:0] cos_v;
        div_t [DIV_LANES-1:0] div;
    } stage_t;

    stage_t pipe_reg  [FRONT_STAGES];
    stage_t pipe_next [FRONT_STAGES];
    logic [FRONT_STAGES-1:0] valid_reg;
    logic [FRONT_STAGES-1:0] valid_next;

    logic [13:0] edge_v [DIV_LANES];
    logic [16:0] coord  [DIV_LANES];

    function automatic logic signed [17:0] sine_q16(input logic [15:0] phase);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [16:0] v;
        idx = phase[13 -: SINE_TABLE_BITS];
        if (phase[14])
            v = SINE_ROM[(SINE_TABLE_BITS+1)'(SINE_N) - {1'b0, idx}];
        else
            v = SINE_ROM[{1'b0, idx}];
        return phase[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic div_t div_step4(input div_t d, input logic [12:0] dv);
        div_t r;
        logic [13:0] r2;
        r = d;
        for (int i = 0; i < 4; i++)
        begin
            r2 = {r.rem, 1'b0};
            if (r2 >= {1'b0, dv})
            begin
                r.rem = 13'(r2 - {1'b0, dv});
                r.quo = {r.quo[14:0], 1'b1};
            end
            else
            begin
                r.rem = r2[12:0];
                r.quo = {r.quo[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [12:0] lane_div(input int lane, input logic [12:0] w,
                                             input logic [12:0] h);
        return (lane < 2) ? w : h;
    endfunction

    always_comb
    begin
        edge_v[0] = mirror_bits[0] ? {1'b0, region_x} + {1'b0, region_w} : {1'b0, region_x};
        edge_v[1] = mirror_bits[0] ? {1'b0, region_x} : {1'b0, region_x} + {1'b0, region_w};
        edge_v[2] = mirror_bits[1] ? {1'b0, region_y} + {1'b0, region_h} : {1'b0, region_y};
        edge_v[3] = mirror_bits[1] ? {1'b0, region_y} : {1'b0, region_y} + {1'b0, region_h};

        pipe_next[0].pos_x   = pos_x;
        pipe_next[0].pos_y   = pos_y;
        pipe_next[0].quad_w  = quad_width;
        pipe_next[0].quad_h  = quad_height;
        pipe_next[0].pivot_x = pivot_x;
        pipe_next[0].pivot_y = pivot_y;
        pipe_next[0].sin_v   = sine_q16(rot_phase);
        pipe_next[0].cos_v   = sine_q16(rot_phase + 16'd16384);
        for (int l = 0; l < DIV_LANES; l++)
        begin
            div_t d0;
            logic [12:0] dv;
            dv = lane_div(l, tex_w, tex_h);
            d0.zero = (dv == 13'd0) && (edge_v[l] == 14'd0);
            d0.sat  = (dv == 13'd0) || (edge_v[l] >= {1'b0, dv});
            d0.rem  = d0.sat ? 13'd0 : edge_v[l][12:0];
            d0.quo  = 16'd0;
            pipe_next[0].div[l] = div_step4(d0, dv);
        end
        valid_next[0] = take;

        for (int s = 1; s < FRONT_STAGES; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
            for (int l = 0; l < DIV_LANES; l++)
                pipe_next[s].div[l] = div_step4(pipe_reg[s-1].div[l],
                                                lane_div(l, tex_w, tex_h));
            valid_next[s] = valid_reg[s-1];
        end
    end

    // round to nearest: add one when the remainder reaches half the divisor
    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            div_t d;
            logic [12:0] dv;
            d = pipe_reg[FRONT_STAGES-1].div[l];
            dv = lane_div(l, tex_w, tex_h);
            if (d.zero)
                coord[l] = 17'd0;
            else if (d.sat)
                coord[l] = 17'd65536;
            else
                coord[l] = {1'b0, d.quo}
                           + 17'(({1'b0, d.rem} + {2'b0, dv[12:1]}) >= {1'b0, dv});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < FRONT_STAGES; s++)
            pipe_reg[s] <= pipe_next[s];
    end

    assign push               = valid_reg[FRONT_STAGES-1];
    assign push_item.pos_x    = pipe_reg[FRONT_STAGES-1].pos_x;
    assign push_item.pos_y    = pipe_reg[FRONT_STAGES-1].pos_y;
    assign push_item.quad_w   = pipe_reg[FRONT_STAGES-1].quad_w;
    assign push_item.quad_h   = pipe_reg[FRONT_STAGES-1].quad_h;
    assign push_item.pivot_x  = pipe_reg[FRONT_STAGES-1].pivot_x;
    assign push_item.pivot_y  = pipe_reg[FRONT_STAGES-1].pivot_y;
    assign push_item.sin_v    = pipe_reg[FRONT_STAGES-1].sin_v;
    assign push_item.cos_v    = pipe_reg[FRONT_STAGES-1].cos_v;
    assign push_item.u0       = coord[0];
    assign push_item.u1       = coord[1];
    assign push_item.v0       = coord[2];
    assign push_item.v1       = coord[3];

endmodule

### hdl/sqs_queue.sv
module sqs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sqs_pkg::sqs_item_t   push_item,
    input  logic                 pop,
    output logic                 empty,
    output sqs_pkg::sqs_item_t   head
);
    import sqs_pkg::*;

    sqs_item_t entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < (QPTR_W+1)'(QDEPTH))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

### hdl/sqs_back.sv
module sqs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  sqs_pkg::sqs_item_t   head,
    output logic                 pop,
    output logic                 strobe,
    output logic signed [23:0]   corner_x,
    output logic signed [23:0]   corner_y,
    output logic [16:0]          tex_u,
    output logic [16:0]          tex_v,
    output logic [1:0]           corner_index,
    output logic                 last_corner
);
    import sqs_pkg::*;

    sqs_item_t item_reg;
    logic [1:0] k_reg, k_next;
    logic       act_reg, act_next;

    // offset stage
    logic               b1_valid_reg;
    logic [1:0]         b1_k_reg;
    logic signed [24:0] b1_ox_reg, b1_oy_reg, b1_ox_next, b1_oy_next;
    logic signed [24:0] b1_bx_reg, b1_by_reg;
    logic signed [17:0] b1_s_reg, b1_c_reg;
    logic [16:0]        b1_u_reg, b1_v_reg;

    // product stage
    logic               b2_valid_reg;
    logic [1:0]         b2_k_reg;
    logic signed [42:0] b2_xc_reg, b2_ys_reg, b2_yc_reg, b2_xs_reg;
    logic signed [24:0] b2_bx_reg, b2_by_reg;
    logic [16:0]        b2_u_reg, b2_v_reg;

    logic signed [43:0] sum_x, sum_y;
    logic signed [28:0] rnd_x, rnd_y;
    logic signed [29:0] full_x, full_y;
    logic signed [23:0] sat_x, sat_y;

    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        if (v > 30'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -30'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    always_comb
    begin
        pop      = !empty && (!act_reg || k_reg == 2'd3);
        k_next   = k_reg;
        act_next = act_reg;
        if (pop)
        begin
            k_next   = 2'd0;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            k_next   = k_reg + 2'd1;
            act_next = (k_reg != 2'd3);
        end
    end

    always_comb
    begin
        b1_ox_next = (k_reg[0] ? $signed({2'b00, item_reg.quad_w}) : 25'sd0)
                     - 25'(item_reg.pivot_x);
        b1_oy_next = (k_reg[1] ? $signed({2'b00, item_reg.quad_h}) : 25'sd0)
                     - 25'(item_reg.pivot_y);
    end

    always_comb
    begin
        sum_x  = 44'(b2_xc_reg) + 44'(b2_ys_reg);
        sum_y  = 44'(b2_yc_reg) - 44'(b2_xs_reg);
        // halves go up: add half an LSB, then floor
        rnd_x  = 29'((45'(sum_x) + 45'sd32768) >>> 16);
        rnd_y  = 29'((45'(sum_y) + 45'sd32768) >>> 16);
        full_x = 30'(rnd_x) + 30'(b2_bx_reg);
        full_y = 30'(rnd_y) + 30'(b2_by_reg);
        sat_x  = sat24(full_x);
        sat_y  = sat24(full_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= 1'b0;
            k_reg        <= 2'd0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            strobe       <= 1'b0;
        end
        else
        begin
            act_reg      <= act_next;
            k_reg        <= k_next;
            b1_valid_reg <= act_reg;
            b2_valid_reg <= b1_valid_reg;
            strobe       <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head;

        b1_k_reg  <= k_reg;
        b1_ox_reg <= b1_ox_next;
        b1_oy_reg <= b1_oy_next;
        b1_bx_reg <= 25'(item_reg.pivot_x) + 25'(item_reg.pos_x);
        b1_by_reg <= 25'(item_reg.pivot_y) + 25'(item_reg.pos_y);
        b1_s_reg  <= item_reg.sin_v;
        b1_c_reg  <= item_reg.cos_v;
        b1_u_reg  <= k_reg[0] ? item_reg.u1 : item_reg.u0;
        b1_v_reg  <= k_reg[1] ? item_reg.v1 : item_reg.v0;

        b2_k_reg  <= b1_k_reg;
        b2_xc_reg <= b1_ox_reg * b1_c_reg;
        b2_ys_reg <= b1_oy_reg * b1_s_reg;
        b2_yc_reg <= b1_oy_reg * b1_c_reg;
        b2_xs_reg <= b1_ox_reg * b1_s_reg;
        b2_bx_reg <= b1_bx_reg;
        b2_by_reg <= b1_by_reg;
        b2_u_reg  <= b1_u_reg;
        b2_v_reg  <= b1_v_reg;

        corner_x     <= sat_x;
        corner_y     <= sat_y;
        tex_u        <= b2_u_reg;
        tex_v        <= b2_v_reg;
        corner_index <= b2_k_reg;
        last_corner  <= (b2_k_reg == 2'd3);
    end

`ifndef SYNTHESIS
    a_corners_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && corner_index != 2'd3 |=> strobe && corner_index == $past(corner_index) + 2'd1)
        else $error("corners of a sprite not contiguous");
    a_sprite_start: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && corner_index == 2'd0 |-> !$past(strobe) || $past(last_corner))
        else $error("sprite started inside another");
    a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pop && act_reg |-> k_reg == 2'd3)
        else $error("item loaded mid sprite");
`endif

endmodule
